/* sv/multizone_presence_gate_core_defines.svh */
// Assertion macros for the multizone presence gate.
// Used by the top level; no other dependencies.
`ifndef MULTIZONE_PRESENCE_GATE_CORE_DEFINES_SVH
`define MULTIZONE_PRESENCE_GATE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked check, ignored while reset is high
`define MPG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked check that also holds during reset
`define MPG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MPG_ASSERT(lbl, prop, msg)
`define MPG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/mpg_pkg.sv */
// Shared types and constants of the multizone presence gate.
// No dependencies; imported by every module of the block.
package mpg_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_MIN_CONFIDENCE = 3'd0;
   localparam logic [2:0] CSR_DELTA_MM       = 3'd1;
   localparam logic [2:0] CSR_MAX_RANGE_MM   = 3'd2;
   localparam logic [2:0] CSR_WARMUP_FRAMES  = 3'd3;
   localparam logic [2:0] CSR_HIT_FRAMES     = 3'd4;
   localparam logic [2:0] CSR_CLEAR_FRAMES   = 3'd5;

   // Valid depth window in millimeters
   localparam logic [15:0] DEPTH_MIN_MM = 16'd80;
   localparam logic [15:0] DEPTH_MAX_MM = 16'd2500;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_WARMUP  = 2'd1,
      MODE_LATCHED = 2'd2,
      MODE_ARMED   = 2'd3
   } frame_mode_type;

   typedef struct packed {
      logic [15:0] min_confidence;
      logic [11:0] delta_mm;
      logic [11:0] max_range_mm;
      logic [7:0]  warmup_frames;
      logic [7:0]  hit_frames;
      logic [7:0]  clear_frames;
   } cfg_type;

   typedef struct packed {
      logic [31:0] frame_seq;
      logic [3:0]  zone_index;
      logic [15:0] zone_depth_mm;
      logic [15:0] zone_confidence;
      logic        last_zone;
   } item_type;

   typedef struct packed {
      logic valid;
      logic close;
      logic learn;
   } eval_type;

endpackage

/* sv/multizone_presence_gate_core.sv */
// Multizone presence gate. Zone reports enter through an input register and
// are judged in one pass against per-zone baselines and close streaks held in
// flip-flops; one report is taken per clock cycle while no last-zone report
// waits. A report with last_zone set yields one transaction on rsp (fired);
// rsp_valid is set in the result register once the report leaves the input
// register. The single result register sets the rate: a last-zone report waits
// in the input register only while the previous result has not been taken.
// Reset clears all baselines and streaks at once; no clearing pass is needed.
module multizone_presence_gate_core #(
   parameter int ZONES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_frame_seq,
   input  logic [3:0]  req_zone_index,
   input  logic [15:0] req_zone_depth_mm,
   input  logic [15:0] req_zone_confidence,
   input  logic        req_last_zone,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fired
);
   import mpg_pkg::*;

`include "multizone_presence_gate_core_defines.svh"

   localparam int         IDX_W      = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam logic [4:0] ZONE_LIMIT = 5'(ZONES);

   cfg_type  cfg;
   item_type req_item;
   item_type it;
   logic     it_valid;
   logic     advance;
   eval_type ev;

   // Frame state
   logic [31:0]    last_seq_ff,    last_seq_in;
   logic [7:0]     warmup_ff,      warmup_in;
   logic           latched_ff,     latched_in;
   logic [7:0]     clear_ff,       clear_in;
   frame_mode_type mode_ff,        mode_in;
   logic           any_close_ff,   any_close_in;
   logic           rising_ff,      rising_in;
   logic [11:0]    baseline_ff [ZONES];
   logic [7:0]     streak_ff   [ZONES];

   // Per-zone write controls
   frame_mode_type mode_cur;
   logic           zone_hit;
   logic [IDX_W-1:0] idx;
   logic [11:0]    base_rd;
   logic [7:0]     streak_rd;
   logic [7:0]     streak_inc;
   logic           base_we;
   logic           streak_we;
   logic [7:0]     streak_wd;
   logic           streak_clr;
   logic           fire;
   logic [7:0]     clear_inc;

   // Result register
   logic           out_valid_ff, out_valid_in;
   logic           fired_ff,     fired_in;
   logic           streak_any;

   mpg_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_item.frame_seq       = req_frame_seq;
   assign req_item.zone_index      = req_zone_index;
   assign req_item.zone_depth_mm   = req_zone_depth_mm;
   assign req_item.zone_confidence = req_zone_confidence;
   assign req_item.last_zone       = req_last_zone;

   // Drain the input register unless a result would be overwritten
   assign advance = it_valid && (!it.last_zone || !out_valid_ff || rsp_ready);

   mpg_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (it_valid),
      .item       (it)
   );

   assign idx       = it.zone_index[IDX_W-1:0];
   assign zone_hit  = {1'b0, it.zone_index} < ZONE_LIMIT;
   assign base_rd   = zone_hit ? baseline_ff[idx] : 12'd0;
   assign streak_rd = zone_hit ? streak_ff[idx] : 8'd0;

   mpg_zone_eval u_eval (
      .cfg        (cfg),
      .depth      (it.zone_depth_mm),
      .confidence (it.zone_confidence),
      .baseline   (base_rd),
      .result     (ev)
   );

   assign streak_inc = (streak_rd == COUNT_MAX) ? streak_rd : streak_rd + 8'd1;
   assign clear_inc  = (clear_ff == COUNT_MAX) ? clear_ff : clear_ff + 8'd1;

   // Judge one zone report and work out the frame state it leaves
   always_comb begin
      last_seq_in  = last_seq_ff;
      warmup_in    = warmup_ff;
      latched_in   = latched_ff;
      clear_in     = clear_ff;
      mode_cur     = mode_ff;
      any_close_in = any_close_ff;
      rising_in    = rising_ff;
      base_we      = 1'b0;
      streak_we    = 1'b0;
      streak_wd    = 8'd0;
      streak_clr   = 1'b0;
      fire         = 1'b0;
      if (advance) begin
         // Open a frame on zone zero, or drop it on a stale sequence
         if (it.zone_index == 4'd0) begin
            any_close_in = 1'b0;
            rising_in    = 1'b0;
            if ((it.frame_seq == 32'd0) || (it.frame_seq == last_seq_ff)) begin
               mode_cur = MODE_IDLE;
            end else begin
               last_seq_in = it.frame_seq;
               if (warmup_ff < cfg.warmup_frames) begin
                  warmup_in = warmup_ff + 8'd1;
                  mode_cur  = MODE_WARMUP;
               end else begin
                  mode_cur = latched_ff ? MODE_LATCHED : MODE_ARMED;
               end
            end
         end

         // Per-zone work
         if ((mode_cur != MODE_IDLE) && zone_hit) begin
            if (mode_cur == MODE_WARMUP) begin
               base_we = ev.learn;
            end else begin
               if (ev.close) begin
                  any_close_in = 1'b1;
               end
               if (mode_cur == MODE_ARMED) begin
                  streak_we = 1'b1;
                  if (ev.close) begin
                     streak_wd = streak_inc;
                     if (streak_inc >= cfg.hit_frames) begin
                        rising_in = 1'b1;
                     end
                  end else begin
                     streak_wd = 8'd0;
                     base_we   = ev.learn;
                  end
               end
            end
         end

         // Close the frame
         if (it.last_zone) begin
            if (mode_cur == MODE_LATCHED) begin
               if (any_close_in) begin
                  clear_in = 8'd0;
               end else if (clear_inc >= cfg.clear_frames) begin
                  latched_in = 1'b0;
                  clear_in   = 8'd0;
               end else begin
                  clear_in = clear_inc;
               end
            end else if ((mode_cur == MODE_ARMED) && rising_in) begin
               streak_clr = 1'b1;
               latched_in = 1'b1;
               clear_in   = 8'd0;
               fire       = 1'b1;
            end
            mode_cur     = MODE_IDLE;
            any_close_in = 1'b0;
            rising_in    = 1'b0;
         end
      end
      mode_in = mode_cur;
   end

   // Hold the result until rsp takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      fired_in     = fired_ff;
      if (advance && it.last_zone) begin
         out_valid_in = 1'b1;
         fired_in     = fire;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= 32'd0;
         warmup_ff    <= 8'd0;
         latched_ff   <= 1'b0;
         clear_ff     <= 8'd0;
         mode_ff      <= MODE_IDLE;
         any_close_ff <= 1'b0;
         rising_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         last_seq_ff  <= last_seq_in;
         warmup_ff    <= warmup_in;
         latched_ff   <= latched_in;
         clear_ff     <= clear_in;
         mode_ff      <= mode_in;
         any_close_ff <= any_close_in;
         rising_ff    <= rising_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
   end

   // Baselines and streaks; a fire clears every streak
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            baseline_ff[z] <= 12'd0;
            streak_ff[z]   <= 8'd0;
         end
      end else begin
         if (base_we) begin
            baseline_ff[idx] <= it.zone_depth_mm[11:0];
         end
         if (streak_clr) begin
            for (int z = 0; z < ZONES; z++) begin
               streak_ff[z] <= 8'd0;
            end
         end else if (streak_we) begin
            streak_ff[idx] <= streak_wd;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_fired = fired_ff;

   // Any nonzero streak, for checking only
   always_comb begin
      streak_any = 1'b0;
      for (int z = 0; z < ZONES; z++) begin
         streak_any = streak_any | (streak_ff[z] != 8'd0);
      end
   end

   `MPG_ASSERT(a_fired_latched, rsp_valid && rsp_fired |-> latched_ff, "fired without latch")
   `MPG_ASSERT(a_no_overwrite, advance && it.last_zone |-> !out_valid_ff || rsp_ready, "result lost")
   `MPG_ASSERT(a_fire_clears, fire |=> !streak_any, "streaks not cleared after fire")
   `MPG_ASSERT(a_frame_closed, advance && it.last_zone |=> mode_ff == MODE_IDLE, "frame left open")
   `MPG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

/* sv/mpg_cfg_regs.sv */
// Configuration register file of the multizone presence gate.
// Depends on mpg_pkg for register indexes and the config struct.
module mpg_cfg_regs (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output mpg_pkg::cfg_type cfg
);
   import mpg_pkg::*;

   cfg_type cfg_ff;

   // Write one register per enabled cycle; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_confidence <= 16'd100;
         cfg_ff.delta_mm       <= 12'd150;
         cfg_ff.max_range_mm   <= 12'd1200;
         cfg_ff.warmup_frames  <= 8'd10;
         cfg_ff.hit_frames     <= 8'd3;
         cfg_ff.clear_frames   <= 8'd10;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_CONFIDENCE: cfg_ff.min_confidence <= csr_wdata;
            CSR_DELTA_MM:       cfg_ff.delta_mm       <= csr_wdata[11:0];
            CSR_MAX_RANGE_MM:   cfg_ff.max_range_mm   <= csr_wdata[11:0];
            CSR_WARMUP_FRAMES:  cfg_ff.warmup_frames  <= csr_wdata[7:0];
            CSR_HIT_FRAMES:     cfg_ff.hit_frames     <= csr_wdata[7:0];
            CSR_CLEAR_FRAMES:   cfg_ff.clear_frames   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/mpg_in_reg.sv */
// Input register of the multizone presence gate: holds one zone report.
// Depends on mpg_pkg for the report struct.
module mpg_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpg_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output mpg_pkg::item_type item
);
   import mpg_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Take a new transaction whenever the slot is empty or drains this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/mpg_zone_eval.sv */
// Per-zone classifier: validity, closeness and baseline learning test.
// Depends on mpg_pkg for the config and result structs.
module mpg_zone_eval (
   input  mpg_pkg::cfg_type  cfg,
   input  logic [15:0]       depth,
   input  logic [15:0]       confidence,
   input  logic [11:0]       baseline,
   output mpg_pkg::eval_type result
);
   import mpg_pkg::*;

   logic        valid;
   logic        has_base;
   logic [16:0] near_sum;
   logic        close_base;
   logic        close_range;

   assign valid = (confidence >= cfg.min_confidence) &&
                  (depth >= DEPTH_MIN_MM) && (depth <= DEPTH_MAX_MM);
   assign has_base = (baseline != 12'd0);

   // Nearer than baseline by more than delta, or within range without baseline
   assign near_sum    = {1'b0, depth} + {5'd0, cfg.delta_mm};
   assign close_base  = near_sum < {5'd0, baseline};
   assign close_range = depth <= {4'd0, cfg.max_range_mm};

   assign result.valid = valid;
   assign result.close = valid && (has_base ? close_base : close_range);
   assign result.learn = valid && (!has_base || (depth < {4'd0, baseline}));

endmodule

/* dv/presence_gate_checker.sv */
// Scoreboard for the multizone presence gate: predicts the fired flag of each
// frame from accepted zone reports and register writes, then checks rsp.
// Depends on mpg_pkg for register indexes, the mode enum and the report struct.
module presence_gate_checker #(
   parameter int ZONES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_frame_seq,
   input  logic [3:0]  req_zone_index,
   input  logic [15:0] req_zone_depth_mm,
   input  logic [15:0] req_zone_confidence,
   input  logic        req_last_zone,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_fired,
   output int          pending,
   output int          mismatches
);
   import mpg_pkg::*;

   // Predicted copy of the gate settings and state
   cfg_type        gate_cfg;
   logic [31:0]    prev_seq;
   logic [7:0]     frames_learned;
   logic [11:0]    floor_mm [16];
   logic [7:0]     streak [16];
   logic           held;
   logic [7:0]     quiet_frames;
   frame_mode_type gate_mode;
   logic           seen_close;
   logic           seen_rising;

   // Fired flags still owed by the block, oldest first
   bit fired_due[$];

   // Keep the nearest valid depth as the zone floor
   task automatic learn_floor(input int z, input int unsigned depth);
      if (floor_mm[z] == '0 || depth < floor_mm[z]) begin
         floor_mm[z] = depth[11:0];
      end
   endtask

   // Advance the gate by one zone report; report whether a frame result is owed
   task automatic judge_report(input item_type rpt, output bit has_result, output bit fired);
      int unsigned depth;
      int          z;
      bit          valid;
      bit          close;
      depth      = 32'(rpt.zone_depth_mm);
      z          = int'(rpt.zone_index);
      close      = 1'b0;
      fired      = 1'b0;
      has_result = 1'b0;

      // Zone zero opens a frame unless its sequence is zero or repeated
      if (rpt.zone_index == '0) begin
         seen_close  = 1'b0;
         seen_rising = 1'b0;
         if (rpt.frame_seq == '0 || rpt.frame_seq == prev_seq) begin
            gate_mode = MODE_IDLE;
         end else begin
            prev_seq = rpt.frame_seq;
            if (frames_learned < gate_cfg.warmup_frames) begin
               frames_learned++;
               gate_mode = MODE_WARMUP;
            end else begin
               gate_mode = held ? MODE_LATCHED : MODE_ARMED;
            end
         end
      end

      // Judge the zone against its floor or the range limit
      if (gate_mode != MODE_IDLE && z < ZONES) begin
         valid = rpt.zone_confidence >= gate_cfg.min_confidence &&
                 depth >= DEPTH_MIN_MM && depth <= DEPTH_MAX_MM;
         if (gate_mode == MODE_WARMUP) begin
            if (valid) learn_floor(z, depth);
         end else begin
            if (valid) begin
               if (floor_mm[z] != '0) close = (depth + gate_cfg.delta_mm) < floor_mm[z];
               else close = depth <= gate_cfg.max_range_mm;
            end
            if (close) seen_close = 1'b1;
            if (gate_mode == MODE_ARMED) begin
               if (close) begin
                  if (streak[z] != COUNT_MAX) streak[z]++;
                  if (streak[z] >= gate_cfg.hit_frames) seen_rising = 1'b1;
               end else begin
                  streak[z] = '0;
                  if (valid) learn_floor(z, depth);
               end
            end
         end
      end

      // Close the frame: unlatch after enough empty frames, or fire
      if (rpt.last_zone) begin
         has_result = 1'b1;
         if (gate_mode == MODE_LATCHED) begin
            if (seen_close) begin
               quiet_frames = '0;
            end else begin
               if (quiet_frames != COUNT_MAX) quiet_frames++;
               if (quiet_frames >= gate_cfg.clear_frames) begin
                  held         = 1'b0;
                  quiet_frames = '0;
               end
            end
         end else if (gate_mode == MODE_ARMED && seen_rising) begin
            foreach (streak[i]) streak[i] = '0;
            held         = 1'b1;
            quiet_frames = '0;
            fired        = 1'b1;
         end
         gate_mode   = MODE_IDLE;
         seen_close  = 1'b0;
         seen_rising = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      item_type rpt;
      bit       has_result;
      bit       fired_now;
      bit       due;
      if (reset) begin
         // Restore register defaults and clear the gate
         gate_cfg.min_confidence = 16'd100;
         gate_cfg.delta_mm       = 12'd150;
         gate_cfg.max_range_mm   = 12'd1200;
         gate_cfg.warmup_frames  = 8'd10;
         gate_cfg.hit_frames     = 8'd3;
         gate_cfg.clear_frames   = 8'd10;
         prev_seq       = '0;
         frames_learned = '0;
         foreach (floor_mm[i]) floor_mm[i] = '0;
         foreach (streak[i]) streak[i] = '0;
         held         = 1'b0;
         quiet_frames = '0;
         gate_mode    = MODE_IDLE;
         seen_close   = 1'b0;
         seen_rising  = 1'b0;
         mismatches   = 0;
         fired_due.delete();
      end else begin
         // Track register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_CONFIDENCE: gate_cfg.min_confidence = csr_wdata;
               CSR_DELTA_MM:       gate_cfg.delta_mm       = csr_wdata[11:0];
               CSR_MAX_RANGE_MM:   gate_cfg.max_range_mm   = csr_wdata[11:0];
               CSR_WARMUP_FRAMES:  gate_cfg.warmup_frames  = csr_wdata[7:0];
               CSR_HIT_FRAMES:     gate_cfg.hit_frames     = csr_wdata[7:0];
               CSR_CLEAR_FRAMES:   gate_cfg.clear_frames   = csr_wdata[7:0];
               default: ;
            endcase
         end

         // Compare each result transaction with the oldest owed flag
         if (rsp_valid && rsp_ready) begin
            if (fired_due.size() == 0) begin
               $display("%0t checker: fired expected none, actual %0b", $time, rsp_fired);
               mismatches++;
            end else begin
               due = fired_due.pop_front();
               if (rsp_fired !== due) begin
                  $display("%0t checker: fired expected %0b, actual %0b", $time, due, rsp_fired);
                  mismatches++;
               end
            end
         end

         // Predict from each accepted report transaction
         if (req_valid && req_ready) begin
            rpt = '{frame_seq: req_frame_seq, zone_index: req_zone_index,
                    zone_depth_mm: req_zone_depth_mm,
                    zone_confidence: req_zone_confidence, last_zone: req_last_zone};
            judge_report(rpt, has_result, fired_now);
            if (has_result) fired_due.push_back(fired_now);
         end
      end
      pending = fired_due.size();
   end

endmodule

/* dv/tb_top.sv */
// Top of the presence gate testbench: clock, reset, register settings, zone
// report stimulus, result back-pressure, watchdog and verdict.
// Depends on mpg_pkg, multizone_presence_gate_core and presence_gate_checker.
module tb_top;
   import mpg_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_frame_seq;
   logic [3:0]  req_zone_index;
   logic [15:0] req_zone_depth_mm;
   logic [15:0] req_zone_confidence;
   logic        req_last_zone;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_fired;

   int          pending;
   int          mismatches;
   int          idle_cycles = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   bit          scene_near [16];
   logic [31:0] seq_now = '0;

   multizone_presence_gate_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_seq       (req_frame_seq),
      .req_zone_index      (req_zone_index),
      .req_zone_depth_mm   (req_zone_depth_mm),
      .req_zone_confidence (req_zone_confidence),
      .req_last_zone       (req_last_zone),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fired           (rsp_fired)
   );

   presence_gate_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_seq       (req_frame_seq),
      .req_zone_index      (req_zone_index),
      .req_zone_depth_mm   (req_zone_depth_mm),
      .req_zone_confidence (req_zone_confidence),
      .req_last_zone       (req_last_zone),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fired           (rsp_fired),
      .pending             (pending),
      .mismatches          (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Stall the result channel for a random number of cycles per transaction
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Offer one zone report after a random gap and hold it until accepted
   task automatic send_report(input logic [31:0] seq, input logic [3:0] zone,
                              input logic [15:0] depth, input logic [15:0] conf,
                              input bit last);
      int gap;
      if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_frame_seq       <= seq;
      req_zone_index      <= zone;
      req_zone_depth_mm   <= depth;
      req_zone_confidence <= conf;
      req_last_zone       <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every owed result is out and the pipeline has settled
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Drain, then rewrite every register
   task automatic load_settings(input logic [15:0] min_conf, input logic [11:0] delta,
                                input logic [11:0] max_range, input logic [7:0] warmup,
                                input logic [7:0] hits, input logic [7:0] clears);
      drain_pipeline();
      write_csr(CSR_MIN_CONFIDENCE, min_conf);
      write_csr(CSR_DELTA_MM, {4'd0, delta});
      write_csr(CSR_MAX_RANGE_MM, {4'd0, max_range});
      write_csr(CSR_WARMUP_FRAMES, {8'd0, warmup});
      write_csr(CSR_HIT_FRAMES, {8'd0, hits});
      write_csr(CSR_CLEAR_FRAMES, {8'd0, clears});
      csr_wr_en <= 1'b0;
   endtask

   // Mostly ascending sequence numbers, with an occasional random jump
   function automatic logic [31:0] next_seq();
      logic [31:0] seq;
      seq = ($urandom_range(0, 7) == 0) ? $urandom() : seq_now + 32'd1;
      if (seq == '0) seq = 32'd1;
      return seq;
   endfunction

   // Near or far depth for a zone, with some edge and out-of-window values
   function automatic logic [15:0] pick_depth(input bit near);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'($urandom_range(0, 65535));
      if (r == 1) begin
         case ($urandom_range(0, 3))
            0: return DEPTH_MIN_MM - 16'd1;
            1: return DEPTH_MIN_MM;
            2: return DEPTH_MAX_MM;
            default: return DEPTH_MAX_MM + 16'd1;
         endcase
      end
      return near ? 16'($urandom_range(80, 600)) : 16'($urandom_range(1700, 2500));
   endfunction

   function automatic logic [15:0] pick_conf();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 99));
         1, 2: return 16'hFFFF;
         default: return 16'($urandom_range(100, 65535));
      endcase
   endfunction

   // Random frames over a slowly changing scene, plus dropped, cut, stray and
   // scrambled reports
   task automatic random_phase(input int budget);
      int          done_items;
      int          kind;
      int          nz;
      bit          cut;
      logic [31:0] seq;
      done_items = 0;
      while (done_items < budget) begin
         foreach (scene_near[k]) if ($urandom_range(0, 5) == 0) scene_near[k] = !scene_near[k];
         kind = $urandom_range(0, 99);
         nz   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
         if (kind < 82) begin
            // well-formed frame, sometimes cut short before its last zone
            cut     = kind >= 74;
            seq_now = next_seq();
            for (int k = 0; k < nz; k++) begin
               send_report(seq_now, k[3:0], pick_depth(scene_near[k]), pick_conf(),
                           (k == nz - 1) && !cut);
            end
            done_items += nz;
         end else if (kind < 88) begin
            // dropped frame: zero or repeated sequence
            seq = $urandom_range(0, 1) ? 32'd0 : seq_now;
            for (int k = 0; k < nz; k++) begin
               send_report(seq, k[3:0], pick_depth(scene_near[k]), pick_conf(), k == nz - 1);
            end
         end else if (kind < 94) begin
            // stray report with no zone-zero opener of its own
            send_report($urandom(), 4'($urandom_range(1, 15)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            done_items++;
         end else begin
            // scrambled frame: repeated and unordered zones, raw field values
            seq_now = next_seq();
            send_report(seq_now, 4'd0, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), nz == 1);
            for (int k = 1; k < nz; k++) begin
               send_report($urandom(), 4'($urandom_range(1, 15)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           k == nz - 1);
            end
            done_items += nz;
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_valid           = 1'b0;
      req_frame_seq       = '0;
      req_zone_index      = '0;
      req_zone_depth_mm   = '0;
      req_zone_confidence = '0;
      req_last_zone       = 1'b0;
      foreach (scene_near[k]) scene_near[k] = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: stray report, zero and repeated sequences, field
      // extremes, a cut frame and a one-report frame, all during warmup
      send_report(32'd7, 4'd3, 16'd500, 16'd500, 1'b1);
      send_report(32'd0, 4'd0, 16'd1000, 16'd500, 1'b1);
      send_report(32'hFFFF_FFFF, 4'd0, 16'd2000, 16'hFFFF, 1'b0);
      send_report(32'hFFFF_FFFF, 4'd1, DEPTH_MIN_MM - 16'd1, 16'hFFFF, 1'b0);
      send_report(32'hFFFF_FFFF, 4'd1, DEPTH_MAX_MM + 16'd1, 16'hFFFF, 1'b0);
      send_report(32'hFFFF_FFFF, 4'd2, DEPTH_MAX_MM, 16'd100, 1'b0);
      send_report(32'hFFFF_FFFF, 4'd2, DEPTH_MIN_MM, 16'd99, 1'b0);
      send_report(32'hFFFF_FFFF, 4'd15, 16'hFFFF, 16'd0, 1'b1);
      send_report(32'hFFFF_FFFF, 4'd0, 16'd1500, 16'd500, 1'b1);
      send_report(32'd1, 4'd0, 16'd1800, 16'd500, 1'b0);
      send_report(32'd2, 4'd0, 16'd1900, 16'd500, 1'b1);

      // No warmup, fire on one close frame, unlatch on one empty frame
      load_settings(16'd100, 12'd150, 12'd1200, 8'd0, 8'd1, 8'd1);
      send_report(32'd3, 4'd0, 16'd1600, 16'd500, 1'b0);
      send_report(32'd3, 4'd1, 16'd1200, 16'd500, 1'b0);
      send_report(32'd3, 4'd3, 16'd1201, 16'd500, 1'b1);
      send_report(32'd4, 4'd0, 16'd1600, 16'd500, 1'b1);
      send_report(32'd5, 4'd0, 16'd2400, 16'd500, 1'b1);
      send_report(32'd6, 4'd0, 16'd1649, 16'd500, 1'b1);
      seq_now = 32'd6;

      // Random phases over several settings, extremes included
      load_settings(16'd100, 12'd150, 12'd1200, 8'd12, 8'd3, 8'd4);
      random_phase(110);
      load_settings(16'd0, 12'd0, 12'd80, 8'd0, 8'd1, 8'd1);
      random_phase(110);
      load_settings(16'hFFFF, 12'd2500, 12'd2500, 8'd0, 8'd255, 8'd255);
      random_phase(90);
      load_settings(16'd64, 12'd300, 12'd1500, 8'd0, 8'd0, 8'd0);
      random_phase(100);
      load_settings(16'($urandom_range(0, 2000)), 12'($urandom_range(0, 2500)),
                    12'($urandom_range(80, 2500)), 8'($urandom_range(0, 20)),
                    8'($urandom_range(1, 8)), 8'($urandom_range(1, 12)));
      random_phase(110);
      load_settings(16'd200, 12'd100, 12'd1000, 8'd255, 8'd2, 8'd3);
      random_phase(50);

      // Wait out the last results, then give the verdict
      drain_pipeline();
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
